@@ hw/rtl/aisx_pkg.sv @@
// Shared types and constants for the array set intersect, except and overlap block.
package aisx_pkg;

  localparam int unsigned SetDepthDefault = 64;
  localparam int unsigned KeyWidthDefault = 64;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned PosWidth   = 16;
  localparam int unsigned ModeWidth  = 2;

  localparam logic [PosWidth-1:0] PosMax = '1;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_RIGHT = 2'd1,
    REQ_LEFT  = 2'd2,
    REQ_END   = 2'd3
  } req_e;

  localparam logic [ModeWidth-1:0] ModeIntersect = 2'd0;
  localparam logic [ModeWidth-1:0] ModeExcept    = 2'd1;

  localparam logic [1:0] OverlapFalse = 2'd0;
  localparam logic [1:0] OverlapTrue  = 2'd1;
  localparam logic [1:0] OverlapNull  = 2'd2;

  localparam logic KindElement = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic clear;
    logic insert;
  } cam_ctrl_t;

  typedef struct packed {
    logic hit;
    logic added;
    logic dropped;
  } cam_stat_t;

endpackage

@@ hw/rtl/aisx_cam.sv @@
// Content-addressed key set with fill count, parallel match and append on miss.
module aisx_cam #(
  parameter int unsigned Depth    = aisx_pkg::SetDepthDefault,
  parameter int unsigned KeyWidth = aisx_pkg::KeyWidthDefault,
  localparam int unsigned CntWidth = $clog2(Depth + 1),
  localparam int unsigned IdxWidth = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  aisx_pkg::cam_ctrl_t      ctrl_i,
  input  logic [KeyWidth-1:0]      key_i,
  output aisx_pkg::cam_stat_t      stat_o,
  output logic [CntWidth-1:0]      count_o
);
  import aisx_pkg::*;

  logic [KeyWidth-1:0] keys_q [Depth];
  logic [CntWidth-1:0] count_q, count_d;
  logic [Depth-1:0]    match;
  logic                full;
  logic                hit;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match[i] = (keys_q[i] == key_i) && (CntWidth'(i) < count_q);
    end
  end

  assign hit  = |match;
  assign full = (count_q == CntWidth'(Depth));

  assign stat_o.hit     = hit;
  assign stat_o.added   = ctrl_i.insert && !hit && !full;
  assign stat_o.dropped = ctrl_i.insert && !hit && full;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (stat_o.added) begin
      count_d = count_q + CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_o.added) begin
      keys_q[count_q[IdxWidth-1:0]] <= key_i;
    end
  end

  assign count_o = count_q;

endmodule

@@ hw/rtl/array_set_intersect_except_overlap.sv @@
// Top level of the array set intersect, except and overlap block.
//
//   Channel   Signals                                   Transfer
//   command   start_i, busy_o, req_type_i, elem_*_i,     start_i && !busy_o
//             keep_right_i
//   result    out_valid_o, out_*_o, overlap_result_o,    out_valid_o, one cycle
//             set_overflow_o
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i       cfg_valid_i && cfg_ready_o
//
// An item is registered at acceptance in the input register, and its result, if any,
// is registered in the result register that drives the result ports; one item is
// taken every cycle, as busy_o stays low.
// Membership is resolved by a combinational parallel compare over both key sets.
// Reset empties both sets, clears the row state and the overflow flag, and selects
// intersect mode. The result side cannot stall, so each result shows for one cycle.
module array_set_intersect_except_overlap #(
  parameter int unsigned SET_DEPTH = aisx_pkg::SetDepthDefault,
  parameter int unsigned KEY_WIDTH = aisx_pkg::KeyWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           req_type_i,
  input  logic signed [aisx_pkg::ValueWidth-1:0] elem_value_i,
  input  logic                                 elem_is_null_i,
  input  logic                                 keep_right_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [aisx_pkg::ModeWidth-1:0]       cfg_data_i,
  output logic                                 out_valid_o,
  output logic                                 out_kind_o,
  output logic signed [aisx_pkg::ValueWidth-1:0] out_value_o,
  output logic                                 out_is_null_o,
  output logic [aisx_pkg::PosWidth-1:0]        out_pos_o,
  output logic [aisx_pkg::PosWidth-1:0]        out_length_o,
  output logic [1:0]                           overlap_result_o,
  output logic                                 set_overflow_o
);
  import aisx_pkg::*;

  localparam int unsigned CntWidth = $clog2(SET_DEPTH + 1);

  // Input register.
  logic                       in_valid_q;
  req_e                       req_q;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic                       null_q;
  logic                       keep_q;

  // Row and block state.
  logic [ModeWidth-1:0] mode_q;
  logic                 right_null_q, right_null_d;
  logic                 emit_null_q, emit_null_d;
  logic [PosWidth-1:0]  left_pos_q, left_pos_d;
  logic                 left_null_q, left_null_d;
  logic                 found_q, found_d;
  logic                 overflow_q, overflow_d;

  // Result register.
  logic                        res_valid_q, res_valid_d;
  logic                        res_kind_q, res_kind_d;
  logic signed [ValueWidth-1:0] res_value_q, res_value_d;
  logic                        res_null_q, res_null_d;
  logic [PosWidth-1:0]         res_pos_q, res_pos_d;
  logic [PosWidth-1:0]         res_len_q, res_len_d;
  logic [1:0]                  res_ovl_q, res_ovl_d;
  logic                        res_flow_q, res_flow_d;

  cam_ctrl_t           right_ctrl, emit_ctrl;
  cam_stat_t           right_stat, emit_stat;
  logic [CntWidth-1:0] right_count, emit_count;

  logic overlap_mode;
  logic intersect_mode;
  logic key_wanted;
  logic null_wanted;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = !in_valid_q;

  assign overlap_mode   = mode_q[1];
  assign intersect_mode = (mode_q == ModeIntersect);
  assign key_wanted     = intersect_mode ? right_stat.hit : !right_stat.hit;
  assign null_wanted    = intersect_mode ? right_null_q : !right_null_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q  <= req_e'(req_type_i);
      key_q  <= elem_value_i[KEY_WIDTH-1:0];
      null_q <= elem_is_null_i;
      keep_q <= keep_right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIntersect;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  aisx_cam #(
    .Depth    (SET_DEPTH),
    .KeyWidth (KEY_WIDTH)
  ) u_right_cam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (right_ctrl),
    .key_i   (key_q),
    .stat_o  (right_stat),
    .count_o (right_count)
  );

  aisx_cam #(
    .Depth    (SET_DEPTH),
    .KeyWidth (KEY_WIDTH)
  ) u_emit_cam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (emit_ctrl),
    .key_i   (key_q),
    .stat_o  (emit_stat),
    .count_o (emit_count)
  );

  always_comb begin
    right_ctrl   = '0;
    emit_ctrl    = '0;
    right_null_d = right_null_q;
    emit_null_d  = emit_null_q;
    left_pos_d   = left_pos_q;
    left_null_d  = left_null_q;
    found_d      = found_q;
    res_valid_d  = 1'b0;
    res_kind_d   = KindElement;
    res_value_d  = '0;
    res_null_d   = 1'b0;
    res_pos_d    = '0;
    res_len_d    = '0;
    res_ovl_d    = OverlapFalse;
    res_flow_d   = overflow_q;
    if (in_valid_q) begin
      unique case (req_q)
        REQ_START: begin
          right_ctrl.clear = !keep_q;
          emit_ctrl.clear  = 1'b1;
          if (!keep_q) begin
            right_null_d = 1'b0;
          end
          emit_null_d = 1'b0;
          left_pos_d  = '0;
          left_null_d = 1'b0;
          found_d     = 1'b0;
        end
        REQ_RIGHT: begin
          if (null_q) begin
            right_null_d = 1'b1;
          end else begin
            right_ctrl.insert = 1'b1;
          end
        end
        REQ_LEFT: begin
          if (left_pos_q != PosMax) begin
            left_pos_d = left_pos_q + PosWidth'(1);
          end
          res_pos_d = left_pos_q;
          if (overlap_mode) begin
            if (null_q) begin
              left_null_d = 1'b1;
            end else if (right_stat.hit) begin
              found_d = 1'b1;
            end
          end else if (null_q) begin
            if (!emit_null_q && null_wanted) begin
              emit_null_d = 1'b1;
              res_valid_d = 1'b1;
              res_null_d  = 1'b1;
            end
          end else begin
            emit_ctrl.insert = key_wanted;
            res_valid_d      = emit_stat.added;
            res_value_d      = ValueWidth'(key_q);
          end
        end
        REQ_END: begin
          res_valid_d = 1'b1;
          res_kind_d  = KindSummary;
          if (overlap_mode) begin
            if (left_pos_q == '0 || (right_count == '0 && !right_null_q)) begin
              res_ovl_d = OverlapFalse;
            end else if (found_q) begin
              res_ovl_d = OverlapTrue;
            end else if (right_null_q || left_null_q) begin
              res_ovl_d = OverlapNull;
            end else begin
              res_ovl_d = OverlapFalse;
            end
          end else begin
            res_len_d = PosWidth'(emit_count) + PosWidth'(emit_null_q);
          end
        end
        default: begin
        end
      endcase
    end
    overflow_d = overflow_q | right_stat.dropped | emit_stat.dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_null_q <= 1'b0;
      emit_null_q  <= 1'b0;
      left_pos_q   <= '0;
      left_null_q  <= 1'b0;
      found_q      <= 1'b0;
      overflow_q   <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      right_null_q <= right_null_d;
      emit_null_q  <= emit_null_d;
      left_pos_q   <= left_pos_d;
      left_null_q  <= left_null_d;
      found_q      <= found_d;
      overflow_q   <= overflow_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q  <= res_kind_d;
    res_value_q <= res_value_d;
    res_null_q  <= res_null_d;
    res_pos_q   <= res_pos_d;
    res_len_q   <= res_len_d;
    res_ovl_q   <= res_ovl_d;
    res_flow_q  <= res_flow_d;
  end

  assign out_valid_o      = res_valid_q;
  assign out_kind_o       = res_kind_q;
  assign out_value_o      = res_value_q;
  assign out_is_null_o    = res_null_q;
  assign out_pos_o        = res_pos_q;
  assign out_length_o     = res_len_q;
  assign overlap_result_o = res_ovl_q;
  assign set_overflow_o   = res_flow_q;

endmodule

@@ hw/rtl/aisx_checker.sv @@
// Port-level checks for the array set intersect, except and overlap block.
module aisx_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   start_i,
  input logic                                   busy_o,
  input logic                                   out_valid_o,
  input logic                                   out_kind_o,
  input logic signed [aisx_pkg::ValueWidth-1:0] out_value_o,
  input logic                                   out_is_null_o,
  input logic [aisx_pkg::PosWidth-1:0]          out_pos_o,
  input logic [aisx_pkg::PosWidth-1:0]          out_length_o,
  input logic [1:0]                             overlap_result_o
);
  import aisx_pkg::*;

  // A result always traces back to an accepted item, through the input and result registers.
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted item");

  a_summary_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KindSummary) |->
      (out_value_o == '0 && !out_is_null_o && out_pos_o == '0))
    else $error("summary carries element fields");

  a_element_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KindElement) |->
      (out_length_o == '0 && overlap_result_o == OverlapFalse))
    else $error("element carries summary fields");

  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_is_null_o) |-> (out_value_o == '0))
    else $error("null element with nonzero value");

  a_overlap_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (overlap_result_o == OverlapFalse || overlap_result_o == OverlapTrue ||
                     overlap_result_o == OverlapNull))
    else $error("overlap result out of range");

endmodule

bind array_set_intersect_except_overlap aisx_checker u_aisx_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .out_valid_o      (out_valid_o),
  .out_kind_o       (out_kind_o),
  .out_value_o      (out_value_o),
  .out_is_null_o    (out_is_null_o),
  .out_pos_o        (out_pos_o),
  .out_length_o     (out_length_o),
  .overlap_result_o (overlap_result_o)
);

@@ test/tb.sv @@
// Self-checking testbench for the array set intersect, except and overlap block.
module tb;
  import aisx_pkg::*;

  localparam logic [ModeWidth-1:0] ModeOverlap = 2'd2;
  localparam logic [ModeWidth-1:0] ModeThree   = 2'd3;
  localparam logic [ValueWidth-1:0] KeyMax  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [ValueWidth-1:0] KeyMin  = 64'h8000_0000_0000_0000;
  localparam logic [ValueWidth-1:0] KeyOnes = 64'hffff_ffff_ffff_ffff;
  localparam logic [ValueWidth-1:0] KeyLone = 64'h5a5a_0f0f_c3c3_3c3c;
  localparam int unsigned SetCap = SetDepthDefault;
  localparam int unsigned RandomItems = 1400;

  typedef struct packed {
    logic                  kind;
    logic [ValueWidth-1:0] value;
    logic                  is_null;
    logic [PosWidth-1:0]   pos;
    logic [PosWidth-1:0]   length;
    logic [1:0]            overlap;
    logic                  overflow;
  } set_result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [ModeWidth-1:0]  mode;
    req_e                  req;
    logic [ValueWidth-1:0] value;
    logic                  is_null;
    logic                  keep;
    logic                  pin;
    set_result_t           res;
  } dir_row_t;

  localparam set_result_t NoRes = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] req_type_i = '0;
  logic signed [ValueWidth-1:0] elem_value_i = '0;
  logic elem_is_null_i = 1'b0;
  logic keep_right_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ModeWidth-1:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_kind_o;
  logic signed [ValueWidth-1:0] out_value_o;
  logic out_is_null_o;
  logic [PosWidth-1:0] out_pos_o;
  logic [PosWidth-1:0] out_length_o;
  logic [1:0] overlap_result_o;
  logic set_overflow_o;

  array_set_intersect_except_overlap uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .elem_value_i     (elem_value_i),
    .elem_is_null_i   (elem_is_null_i),
    .keep_right_i     (keep_right_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_kind_o       (out_kind_o),
    .out_value_o      (out_value_o),
    .out_is_null_o    (out_is_null_o),
    .out_pos_o        (out_pos_o),
    .out_length_o     (out_length_o),
    .overlap_result_o (overlap_result_o),
    .set_overflow_o   (set_overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("array_set_intersect_except_overlap: mismatch");
    $finish;
  end

  // Directed rows: an expectation is typed in only where it is plain at a glance.
  dir_row_t directed [31] = '{
    '{1'b0, ModeIntersect, REQ_END, 64'd0, 1'b0, 1'b0, 1'b1,
      '{KindSummary, 64'd0, 1'b0, 16'd0, 16'd0, OverlapFalse, 1'b0}},
    '{1'b0, ModeIntersect, REQ_START, KeyOnes, 1'b1, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_RIGHT, KeyMax, 1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_RIGHT, KeyMin, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_RIGHT, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_RIGHT, KeyOnes, 1'b1, 1'b1, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_RIGHT, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_LEFT, KeyMin, 1'b0, 1'b0, 1'b1,
      '{KindElement, KeyMin, 1'b0, 16'd0, 16'd0, OverlapFalse, 1'b0}},
    '{1'b0, ModeIntersect, REQ_LEFT, KeyMax, 1'b0, 1'b0, 1'b1,
      '{KindElement, KeyMax, 1'b0, 16'd1, 16'd0, OverlapFalse, 1'b0}},
    '{1'b0, ModeIntersect, REQ_LEFT, KeyMin, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_LEFT, KeyOnes, 1'b1, 1'b0, 1'b1,
      '{KindElement, 64'd0, 1'b1, 16'd3, 16'd0, OverlapFalse, 1'b0}},
    '{1'b0, ModeIntersect, REQ_LEFT, KeyOnes, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeIntersect, REQ_END, 64'd0, 1'b0, 1'b0, 1'b1,
      '{KindSummary, 64'd0, 1'b0, 16'd0, 16'd3, OverlapFalse, 1'b0}},
    '{1'b0, ModeIntersect, REQ_END, KeyOnes, 1'b1, 1'b1, 1'b1,
      '{KindSummary, 64'd0, 1'b0, 16'd0, 16'd3, OverlapFalse, 1'b0}},
    '{1'b1, ModeExcept, REQ_START, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeExcept, REQ_START, 64'd0, 1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, ModeExcept, REQ_LEFT, 64'd5, 1'b0, 1'b0, 1'b1,
      '{KindElement, 64'd5, 1'b0, 16'd0, 16'd0, OverlapFalse, 1'b0}},
    '{1'b0, ModeExcept, REQ_LEFT, 64'd0, 1'b1, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeExcept, REQ_LEFT, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeExcept, REQ_END, 64'd0, 1'b0, 1'b0, 1'b1,
      '{KindSummary, 64'd0, 1'b0, 16'd0, 16'd1, OverlapFalse, 1'b0}},
    '{1'b1, ModeOverlap, REQ_START, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeOverlap, REQ_START, 64'd0, 1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, ModeOverlap, REQ_LEFT, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeOverlap, REQ_END, 64'd0, 1'b0, 1'b0, 1'b1,
      '{KindSummary, 64'd0, 1'b0, 16'd0, 16'd0, OverlapTrue, 1'b0}},
    '{1'b0, ModeOverlap, REQ_START, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeOverlap, REQ_END, 64'd0, 1'b0, 1'b0, 1'b1,
      '{KindSummary, 64'd0, 1'b0, 16'd0, 16'd0, OverlapFalse, 1'b0}},
    '{1'b1, ModeThree, REQ_START, 64'd0, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeThree, REQ_RIGHT, 64'd0, 1'b1, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeThree, REQ_LEFT, 64'd7, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, ModeThree, REQ_END, 64'd0, 1'b0, 1'b0, 1'b1,
      '{KindSummary, 64'd0, 1'b0, 16'd0, 16'd0, OverlapNull, 1'b0}},
    '{1'b1, ModeIntersect, REQ_START, 64'd0, 1'b0, 1'b0, 1'b0, NoRes}
  };

  logic [ModeWidth-1:0] set_mode = ModeIntersect;
  logic [ValueWidth-1:0] right_set[$];
  logic [ValueWidth-1:0] emitted_set[$];
  bit right_null;
  bit emitted_null;
  logic [PosWidth-1:0] left_pos = '0;
  bit left_null;
  bit overlap_hit;
  bit set_full;

  set_result_t awaited_results[$];
  int errors = 0;
  int sent = 0;
  int idle_pct = 11;
  bit pin_valid = 1'b0;
  set_result_t pin_res = '0;
  logic [ValueWidth-1:0] key_pool [8];

  function automatic bit key_in(input logic [ValueWidth-1:0] keys[$],
                                input logic [ValueWidth-1:0] key);
    foreach (keys[i]) if (keys[i] == key) return 1'b1;
    return 1'b0;
  endfunction

  task automatic apply_set_op(input req_e req, input logic [ValueWidth-1:0] value,
                              input logic is_null, input logic keep,
                              output bit has, output set_result_t res);
    logic [PosWidth-1:0] pos;
    bit found;
    bit emit;
    res = '0;
    has = 1'b0;
    case (req)
      REQ_START: begin
        if (!keep) begin
          right_set.delete();
          right_null = 1'b0;
        end
        emitted_set.delete();
        emitted_null = 1'b0;
        left_pos = '0;
        left_null = 1'b0;
        overlap_hit = 1'b0;
      end
      REQ_RIGHT: begin
        if (is_null) begin
          right_null = 1'b1;
        end else if (!key_in(right_set, value)) begin
          if (right_set.size() >= SetCap) set_full = 1'b1;
          else right_set.push_back(value);
        end
      end
      REQ_END: begin
        has = 1'b1;
        res.kind = KindSummary;
        if (set_mode[1]) begin
          if (left_pos == 0 || (right_set.size() == 0 && !right_null)) begin
            res.overlap = OverlapFalse;
          end else if (overlap_hit) begin
            res.overlap = OverlapTrue;
          end else if (right_null || left_null) begin
            res.overlap = OverlapNull;
          end else begin
            res.overlap = OverlapFalse;
          end
        end else begin
          res.length = PosWidth'(emitted_set.size()) + PosWidth'(emitted_null);
        end
      end
      default: begin
        pos = left_pos;
        if (left_pos != PosMax) left_pos++;
        if (set_mode[1]) begin
          if (is_null) left_null = 1'b1;
          else if (key_in(right_set, value)) overlap_hit = 1'b1;
        end else if (is_null) begin
          emit = (set_mode == ModeIntersect) ? right_null : !right_null;
          if (emit && !emitted_null) begin
            emitted_null = 1'b1;
            has = 1'b1;
            res.is_null = 1'b1;
            res.pos = pos;
          end
        end else begin
          found = key_in(right_set, value);
          emit = (set_mode == ModeIntersect) ? found : !found;
          if (emit && !key_in(emitted_set, value)) begin
            if (emitted_set.size() >= SetCap) begin
              set_full = 1'b1;
            end else begin
              emitted_set.push_back(value);
              has = 1'b1;
              res.value = value;
              res.pos = pos;
            end
          end
        end
      end
    endcase
    res.overflow = set_full;
  endtask

  always @(posedge clk_i) begin
    set_result_t got;
    set_result_t want;
    set_result_t next;
    bit has;
    if (rst_ni) begin
      if (out_valid_o !== 1'b0) begin
        got = '{out_kind_o, out_value_o, out_is_null_o, out_pos_o, out_length_o,
                overlap_result_o, set_overflow_o};
        if (awaited_results.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: kind %0d value %h null %0d pos %0d len %0d",
                     got.kind, got.value, got.is_null, got.pos, got.length);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("expected kind %0d value %h null %0d pos %0d len %0d ovl %0d ovf %0d",
                       want.kind, want.value, want.is_null, want.pos, want.length,
                       want.overlap, want.overflow);
              $display("     got kind %0d value %h null %0d pos %0d len %0d ovl %0d ovf %0d",
                       got.kind, got.value, got.is_null, got.pos, got.length,
                       got.overlap, got.overflow);
            end
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) set_mode = cfg_data_i;
      if (start_i && !busy_o) begin
        apply_set_op(req_e'(req_type_i), elem_value_i, elem_is_null_i, keep_right_i,
                     has, next);
        if (pin_valid) awaited_results.push_back(pin_res);
        else if (has) awaited_results.push_back(next);
      end
    end
  end

  task automatic send_item(input req_e req, input logic [ValueWidth-1:0] value,
                           input logic is_null, input logic keep,
                           input bit pin = 1'b0, input set_result_t pinned = '0);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_type_i <= req;
    elem_value_i <= value;
    elem_is_null_i <= is_null;
    keep_right_i <= keep;
    pin_valid = pin;
    pin_res = pinned;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  // Stops issuing and waits until every result is in and the pipeline is empty.
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    pin_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [ModeWidth-1:0] mode);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ValueWidth-1:0] pick_key();
    if ($urandom_range(9) < 7) return key_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  task automatic send_row();
    int n_right;
    int n_left;
    bit big;
    big = ($urandom_range(11) == 0);
    n_right = big ? $urandom_range(70, 66) : $urandom_range(6);
    n_left = big ? $urandom_range(70, 60) : $urandom_range(8);
    send_item(REQ_START, {$urandom, $urandom}, $urandom_range(1), $urandom_range(3) == 0);
    repeat (n_right)
      send_item(REQ_RIGHT, big ? {$urandom, $urandom} : pick_key(),
                $urandom_range(9) == 0, $urandom_range(1));
    repeat (n_left)
      send_item(REQ_LEFT, big ? {$urandom, $urandom} : pick_key(),
                $urandom_range(9) == 0, $urandom_range(1));
    send_item(REQ_END, {$urandom, $urandom}, $urandom_range(1), $urandom_range(1));
    if ($urandom_range(7) == 0)
      send_item(REQ_END, {$urandom, $urandom}, $urandom_range(1), $urandom_range(1));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(8, 3))
      send_item(req_e'($urandom_range(3)), pick_key(), $urandom_range(1), $urandom_range(1));
  endtask

  initial begin
    logic [ModeWidth-1:0] phase_modes [4];
    int base;
    int phase;
    phase_modes = '{ModeExcept, ModeOverlap, ModeThree, ModeIntersect};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_mode(directed[i].mode);
      end else begin
        send_item(directed[i].req, directed[i].value, directed[i].is_null,
                  directed[i].keep, directed[i].pin, directed[i].res);
      end
    end

    // One long row, sent back to back.
    idle_pct = 0;
    send_item(REQ_START, 64'd0, 1'b0, 1'b0);
    send_item(REQ_RIGHT, KeyLone, 1'b0, 1'b0);
    repeat (300) send_item(REQ_LEFT, {$urandom, $urandom}, 1'b0, 1'b0);
    send_item(REQ_LEFT, KeyLone, 1'b0, 1'b0);
    send_item(REQ_LEFT, 64'd0, 1'b1, 1'b0);
    send_item(REQ_END, 64'd0, 1'b0, 1'b0);
    idle_pct = 11;

    base = sent;
    phase = 0;
    while (sent - base < RandomItems) begin
      settle();
      write_mode(phase_modes[phase % 4]);
      key_pool = '{KeyMax, KeyMin, 64'd0, KeyOnes, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(15))};
      repeat (10) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_row();
      end
      phase++;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("array_set_intersect_except_overlap: match");
    end else begin
      $display("array_set_intersect_except_overlap: mismatch");
    end
    $finish;
  end

endmodule
